>>> design/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared constants for the binary classification score block.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int COUNT_BITS_DEF  = 24;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int TH_BITS    = 16;
  localparam int BETA_BITS  = 16;
  localparam int RATIO_BITS = 17;
  localparam int FLAG_BITS  = 2;

  localparam logic [RATIO_BITS-1:0] ONE_Q16 = 17'h10000;
  localparam logic [RATIO_BITS-1:0] EMPTY_RESET = 17'h10000;
  localparam logic [BETA_BITS-1:0]  BETA_RESET  = 16'd4096;
  localparam logic [RATIO_BITS-1:0] BETA_ONE    = 17'd4096;

  localparam int CFG_ADDR_BITS = 4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SCORE_TH = 4'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TRUTH_TH = 4'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_BETA_SQ  = 4'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_EMPTY    = 4'd3;

  // counter slots
  localparam logic [1:0] CNT_TP = 2'd0;
  localparam logic [1:0] CNT_TN = 2'd1;
  localparam logic [1:0] CNT_FP = 2'd2;
  localparam logic [1:0] CNT_FN = 2'd3;

endpackage

>>> design/bcs_count.sv
// ----------------------------------------------------------------------------
// bcs_count
// Pixel classifier and four saturating confusion counters.
// ----------------------------------------------------------------------------
module bcs_count #(
  parameter int COUNT_BITS  = bcs_pkg::COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = bcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            upd,
  input  logic                            clr,
  input  logic [SAMPLE_BITS-1:0]          score,
  input  logic [SAMPLE_BITS-1:0]          truth,
  input  logic [bcs_pkg::TH_BITS-1:0]     score_th,
  input  logic [bcs_pkg::TH_BITS-1:0]     truth_th,
  output logic [3:0][COUNT_BITS-1:0]      cnt_inc
);

  localparam int CMP_BITS = (SAMPLE_BITS > bcs_pkg::TH_BITS) ? SAMPLE_BITS : bcs_pkg::TH_BITS;

  logic [3:0][COUNT_BITS-1:0] cnt;
  logic                       pred_pos;
  logic                       act_pos;
  logic [1:0]                 sel;

  assign pred_pos = CMP_BITS'(score) >= CMP_BITS'(score_th);
  assign act_pos  = CMP_BITS'(truth) > CMP_BITS'(truth_th);

  always_comb begin
    if (pred_pos) begin
      sel = act_pos ? bcs_pkg::CNT_TP : bcs_pkg::CNT_FP;
    end else begin
      sel = act_pos ? bcs_pkg::CNT_FN : bcs_pkg::CNT_TN;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (sel == 2'(i) && cnt[i] != {COUNT_BITS{1'b1}}) begin
        cnt_inc[i] = cnt[i] + COUNT_BITS'(1);
      end else begin
        cnt_inc[i] = cnt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      cnt <= '0;
    end else if (upd) begin
      cnt <= cnt_inc;
    end
  end

endmodule

>>> design/bcs_div.sv
// ----------------------------------------------------------------------------
// bcs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcs_div #(
  parameter int DEN_BITS = 34
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [DEN_BITS+bcs_pkg::RATIO_BITS-1:0]   num,
  input  logic [DEN_BITS-1:0]                       den,
  output logic                                      busy,
  output logic                                      done,
  output logic [bcs_pkg::RATIO_BITS-1:0]            quo
);

  localparam int QB       = bcs_pkg::RATIO_BITS;
  localparam int CNT_BITS = $clog2(QB);

  // num must be below den * 2^QB so the top part starts below den
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den_r;
  logic [QB-1:0]       low;
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS:0]   rem_sh;
  logic [DEN_BITS:0]   rem_sub;
  logic                ge;

  assign rem_sh  = {rem, low[QB-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[DEN_BITS+QB-1:QB];
      low   <= num[QB-1:0];
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
      low <= {low[QB-2:0], 1'b0};
      quo <= {quo[QB-2:0], ge};
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

>>> design/binary_classification_scores_top.sv
// ----------------------------------------------------------------------------
// binary_classification_scores_top
// Confusion counters over a pixel stream with per-frame ratio scores.
// ----------------------------------------------------------------------------
// Each pixel transfer classifies one (score, truth) pair and bumps one of four
// saturating counters; pixels are taken back to back. The pixel marked tlast
// closes the frame: its counts are captured, the counters clear, and a
// sequencer runs precision, recall, true-negative rate, accuracy and F-beta
// through one shared 17-step restoring divider, with the F-beta products from
// one shared multiplier. A frame close therefore holds s_tready low until the
// result is loaded into the output register; ratios that fall to a fixed value
// skip their division. The result waits in an output register while the next
// frame streams in.
module binary_classification_scores_top #(
  parameter int COUNT_BITS  = bcs_pkg::COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = bcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [bcs_pkg::CFG_ADDR_BITS-1:0]        cfg_addr,
  input  logic [bcs_pkg::RATIO_BITS-1:0]           cfg_wdata,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // score, truth
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
  input  logic                                     s_tlast,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // true_pos, true_neg, false_pos, false_neg, precision_q, recall_q,
  // specificity_q, accuracy_q, fbeta_q
  output logic [((4*COUNT_BITS+5*bcs_pkg::RATIO_BITS+7)/8)*8-1:0] m_tdata,
  // undefined_flags
  output logic [bcs_pkg::FLAG_BITS-1:0]            m_tuser
);

  localparam int RB        = bcs_pkg::RATIO_BITS;
  localparam int SUM_BITS  = COUNT_BITS + 2;
  localparam int DEN_BITS  = (SUM_BITS > 34) ? SUM_BITS : 34;
  localparam int NUM_BITS  = DEN_BITS + RB;
  localparam int MA_BITS   = 34;
  localparam int MP_BITS   = MA_BITS + RB;
  localparam int OUT_BITS  = ((4*COUNT_BITS+5*RB+7)/8)*8;
  localparam int PAY_BITS  = 4*COUNT_BITS + 5*RB;
  localparam int OFF_FB    = 4*COUNT_BITS + 4*RB;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RATIO    = 4'd1;
  localparam logic [3:0] S_DIV_WAIT = 4'd2;
  localparam logic [3:0] S_MUL1     = 4'd3;
  localparam logic [3:0] S_MUL2     = 4'd4;
  localparam logic [3:0] S_MUL3     = 4'd5;
  localparam logic [3:0] S_FB_DEN   = 4'd6;
  localparam logic [3:0] S_FB_START = 4'd7;
  localparam logic [3:0] S_FB_WAIT  = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  logic [bcs_pkg::TH_BITS-1:0]   score_th;
  logic [bcs_pkg::TH_BITS-1:0]   truth_th;
  logic [bcs_pkg::BETA_BITS-1:0] beta_sq;
  logic [RB-1:0]                 empty_val;
  logic [RB-1:0]                 fallback;

  logic [3:0]                    state;
  logic [1:0]                    job;
  logic                          pix_xfer;
  logic                          frame_end;
  logic [3:0][COUNT_BITS-1:0]    cnt_inc;
  logic [3:0][COUNT_BITS-1:0]    snap;
  logic [3:0][RB-1:0]            ratio;
  logic [RB-1:0]                 fbeta;

  logic [SUM_BITS-1:0]           sum_tpfp;
  logic [SUM_BITS-1:0]           sum_tpfn;
  logic [SUM_BITS-1:0]           sum_tnfp;
  logic [SUM_BITS-1:0]           sum_all;
  logic [SUM_BITS-1:0]           sum_tptn;

  logic                          r_special;
  logic [RB-1:0]                 r_special_val;
  logic [SUM_BITS-1:0]           r_num;
  logic [SUM_BITS-1:0]           r_den;

  logic [MA_BITS-1:0]            mul_a;
  logic [RB-1:0]                 mul_b;
  logic [MP_BITS-1:0]            mul_res;
  logic [MP_BITS-1:0]            num_fb;
  logic [MA_BITS-1:0]            den_fb;

  logic                          div_start;
  logic [NUM_BITS-1:0]           div_num;
  logic [DEN_BITS-1:0]           div_den;
  logic                          div_busy;
  logic                          div_done;
  logic [RB-1:0]                 div_quo;
  logic [RB-1:0]                 quo_sat;
  logic [PAY_BITS-1:0]           payload;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      score_th  <= '0;
      truth_th  <= '0;
      beta_sq   <= bcs_pkg::BETA_RESET;
      empty_val <= bcs_pkg::EMPTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bcs_pkg::REG_SCORE_TH: score_th  <= cfg_wdata[bcs_pkg::TH_BITS-1:0];
        bcs_pkg::REG_TRUTH_TH: truth_th  <= cfg_wdata[bcs_pkg::TH_BITS-1:0];
        bcs_pkg::REG_BETA_SQ:  beta_sq   <= cfg_wdata[bcs_pkg::BETA_BITS-1:0];
        bcs_pkg::REG_EMPTY:    empty_val <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign fallback = (empty_val > bcs_pkg::ONE_Q16) ? bcs_pkg::ONE_Q16 : empty_val;

  assign s_tready  = (state == S_IDLE);
  assign pix_xfer  = s_tvalid && s_tready;
  assign frame_end = pix_xfer && s_tlast;

  bcs_count #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_count (
    .clk      (clk),
    .rst      (rst),
    .upd      (pix_xfer),
    .clr      (frame_end),
    .score    (s_tdata[SAMPLE_BITS-1:0]),
    .truth    (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .score_th (score_th),
    .truth_th (truth_th),
    .cnt_inc  (cnt_inc)
  );

  assign sum_tpfp = SUM_BITS'(snap[bcs_pkg::CNT_TP]) + SUM_BITS'(snap[bcs_pkg::CNT_FP]);
  assign sum_tpfn = SUM_BITS'(snap[bcs_pkg::CNT_TP]) + SUM_BITS'(snap[bcs_pkg::CNT_FN]);
  assign sum_tnfp = SUM_BITS'(snap[bcs_pkg::CNT_TN]) + SUM_BITS'(snap[bcs_pkg::CNT_FP]);
  assign sum_tptn = SUM_BITS'(snap[bcs_pkg::CNT_TP]) + SUM_BITS'(snap[bcs_pkg::CNT_TN]);
  assign sum_all  = sum_tptn + SUM_BITS'(snap[bcs_pkg::CNT_FP])
                  + SUM_BITS'(snap[bcs_pkg::CNT_FN]);

  // ratio job select: precision, recall, tnr, accuracy
  always_comb begin
    r_special     = 1'b0;
    r_special_val = '0;
    r_num         = '0;
    r_den         = '0;
    unique case (job)
      2'd0: begin
        r_special     = (snap[bcs_pkg::CNT_TP] == '0);
        r_special_val = (snap[bcs_pkg::CNT_FP] != '0) ? '0 : fallback;
        r_num         = SUM_BITS'(snap[bcs_pkg::CNT_TP]);
        r_den         = sum_tpfp;
      end
      2'd1: begin
        r_special     = (snap[bcs_pkg::CNT_TP] == '0);
        r_special_val = (snap[bcs_pkg::CNT_FN] != '0) ? '0 : fallback;
        r_num         = SUM_BITS'(snap[bcs_pkg::CNT_TP]);
        r_den         = sum_tpfn;
      end
      2'd2: begin
        r_special = (sum_tnfp == '0);
        r_num     = SUM_BITS'(snap[bcs_pkg::CNT_TN]);
        r_den     = sum_tnfp;
      end
      default: begin
        r_special = (sum_all == '0);
        r_num     = sum_tptn;
        r_den     = sum_all;
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL1: begin
        mul_a = MA_BITS'(bcs_pkg::BETA_ONE) + MA_BITS'(beta_sq);
        mul_b = ratio[0];
      end
      S_MUL2: begin
        mul_a = mul_res[MA_BITS-1:0];
        mul_b = ratio[1];
      end
      S_MUL3: begin
        mul_a = MA_BITS'(beta_sq);
        mul_b = ratio[0];
      end
      default: ;
    endcase
  end

  always_comb begin
    if (state == S_FB_START) begin
      div_num = NUM_BITS'(num_fb) + NUM_BITS'(den_fb >> 1);
      div_den = DEN_BITS'(den_fb);
    end else begin
      div_num = (NUM_BITS'(r_num) << 16) + NUM_BITS'(r_den >> 1);
      div_den = DEN_BITS'(r_den);
    end
  end

  assign div_start = (state == S_FB_START) || (state == S_RATIO && !r_special);

  bcs_div #(
    .DEN_BITS (DEN_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign quo_sat = (div_quo > bcs_pkg::ONE_Q16) ? bcs_pkg::ONE_Q16 : div_quo;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (frame_end) begin
            state <= S_RATIO;
            job   <= '0;
          end
        end
        S_RATIO: begin
          if (!r_special) begin
            state <= S_DIV_WAIT;
          end else if (job == 2'd3) begin
            state <= S_MUL1;
          end else begin
            job <= job + 2'd1;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (job == 2'd3) begin
              state <= S_MUL1;
            end else begin
              job   <= job + 2'd1;
              state <= S_RATIO;
            end
          end
        end
        S_MUL1: begin
          state <= (ratio[0] == '0 || ratio[1] == '0) ? S_OUT : S_MUL2;
        end
        S_MUL2:     state <= S_MUL3;
        S_MUL3:     state <= S_FB_DEN;
        S_FB_DEN:   state <= S_FB_START;
        S_FB_START: state <= S_FB_WAIT;
        S_FB_WAIT: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (frame_end) begin
      snap <= cnt_inc;
    end
    if (state == S_RATIO && r_special) begin
      ratio[job] <= r_special_val;
    end
    if (state == S_DIV_WAIT && div_done) begin
      ratio[job] <= quo_sat;
    end
    if (state == S_MUL1 || state == S_MUL2 || state == S_MUL3) begin
      mul_res <= MP_BITS'(mul_a * mul_b);
    end
    if (state == S_MUL1) begin
      fbeta <= '0;
    end
    if (state == S_MUL3) begin
      num_fb <= mul_res;
    end
    if (state == S_FB_DEN) begin
      den_fb <= mul_res[MA_BITS-1:0] + (MA_BITS'(ratio[1]) << 12);
    end
    if (state == S_FB_WAIT && div_done) begin
      fbeta <= quo_sat;
    end
  end

  assign payload = {fbeta, ratio[3], ratio[2], ratio[1], ratio[0],
                    snap[bcs_pkg::CNT_FN], snap[bcs_pkg::CNT_FP],
                    snap[bcs_pkg::CNT_TN], snap[bcs_pkg::CNT_TP]};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_BITS'(payload);
      m_tuser <= {sum_all == '0, sum_tnfp == '0};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT || state == S_FB_WAIT))
    else $error("divider result outside a wait state");

  assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_DIV_WAIT || state == S_FB_WAIT))
    else $error("divider running outside a wait state");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("pixel taken while scores are computed");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OFF_FB +: RB] <= bcs_pkg::ONE_Q16)
    else $error("f-beta above one");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tuser[1])
    else $error("empty frame reported");

endmodule

>>> dv/bcs_score_checker.sv
// ----------------------------------------------------------------------------
// bcs_score_checker
// Watches the register port and both streams of the classification score
// block, keeps its own confusion counters and settings, works out the scores
// of each closed frame and compares every result transfer field by field
// against the oldest pending frame.
// ----------------------------------------------------------------------------
module bcs_score_checker #(
  parameter int CNT_W = bcs_pkg::COUNT_BITS_DEF,
  parameter int SMP_W = bcs_pkg::SAMPLE_BITS_DEF,
  parameter int PIX_W = ((2*SMP_W+7)/8)*8,
  parameter int RES_W = ((4*CNT_W+5*bcs_pkg::RATIO_BITS+7)/8)*8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bcs_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [bcs_pkg::RATIO_BITS-1:0]    cfg_wdata,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [PIX_W-1:0]                  s_tdata,
  input  logic                              s_tlast,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [RES_W-1:0]                  m_tdata,
  input  logic [bcs_pkg::FLAG_BITS-1:0]     m_tuser,
  output int                                pending,
  output int                                errors,
  output int                                pixels_taken,
  output int                                frames_checked
);
  import bcs_pkg::*;

  localparam int R = RATIO_BITS;

  typedef struct packed {
    logic [CNT_W-1:0]     tp;
    logic [CNT_W-1:0]     tn;
    logic [CNT_W-1:0]     fp;
    logic [CNT_W-1:0]     fn;
    logic [R-1:0]         prec;
    logic [R-1:0]         rec;
    logic [R-1:0]         spec;
    logic [R-1:0]         acc;
    logic [R-1:0]         fbeta;
    logic [FLAG_BITS-1:0] flags;
  } frame_scores_t;

  frame_scores_t expected_scores[$];

  logic [CNT_W-1:0]     n_tp, n_tn, n_fp, n_fn;
  logic [TH_BITS-1:0]   th_score, th_truth;
  logic [BETA_BITS-1:0] beta_sq;
  logic [R-1:0]         empty_val;

  function automatic logic [CNT_W-1:0] sat_incr(logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // num/den as Q1.16, round half up, capped at one
  function automatic logic [R-1:0] q16_of(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (den == 0)
      return '0;
    q = (num * 64'd65536 + den / 2) / den;
    return (q > 64'd65536) ? ONE_Q16 : q[R-1:0];
  endfunction

  task automatic report_mismatch(string what, longint unsigned got_v,
                                 longint unsigned want_v);
    errors++;
    if (errors <= 100)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got_v, want_v);
  endtask

  always @(posedge clk) begin : watch
    frame_scores_t   want, got;
    logic [SMP_W-1:0] sc, tr;
    logic            pred_pos, act_pos;
    logic [R-1:0]    fill;
    longint unsigned ltp, ltn, lfp, lfn, fnum, fden, fq;
    if (rst) begin
      expected_scores.delete();
      n_tp = '0;
      n_tn = '0;
      n_fp = '0;
      n_fn = '0;
      th_score = '0;
      th_truth = '0;
      beta_sq = BETA_RESET;
      empty_val = EMPTY_RESET;
      errors = 0;
      pixels_taken = 0;
      frames_checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SCORE_TH: th_score = cfg_wdata[TH_BITS-1:0];
          REG_TRUTH_TH: th_truth = cfg_wdata[TH_BITS-1:0];
          REG_BETA_SQ:  beta_sq = cfg_wdata[BETA_BITS-1:0];
          REG_EMPTY:    empty_val = cfg_wdata;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        got.tp    = m_tdata[0 +: CNT_W];
        got.tn    = m_tdata[CNT_W +: CNT_W];
        got.fp    = m_tdata[2*CNT_W +: CNT_W];
        got.fn    = m_tdata[3*CNT_W +: CNT_W];
        got.prec  = m_tdata[4*CNT_W +: R];
        got.rec   = m_tdata[4*CNT_W+R +: R];
        got.spec  = m_tdata[4*CNT_W+2*R +: R];
        got.acc   = m_tdata[4*CNT_W+3*R +: R];
        got.fbeta = m_tdata[4*CNT_W+4*R +: R];
        got.flags = m_tuser;
        if (expected_scores.size() == 0) begin
          report_mismatch("result transfer with no frame pending", 1, 0);
        end else begin
          want = expected_scores.pop_front();
          frames_checked++;
          if (got.tp !== want.tp)       report_mismatch("true_pos", got.tp, want.tp);
          if (got.tn !== want.tn)       report_mismatch("true_neg", got.tn, want.tn);
          if (got.fp !== want.fp)       report_mismatch("false_pos", got.fp, want.fp);
          if (got.fn !== want.fn)       report_mismatch("false_neg", got.fn, want.fn);
          if (got.prec !== want.prec)   report_mismatch("precision_q", got.prec, want.prec);
          if (got.rec !== want.rec)     report_mismatch("recall_q", got.rec, want.rec);
          if (got.spec !== want.spec)   report_mismatch("specificity_q", got.spec, want.spec);
          if (got.acc !== want.acc)     report_mismatch("accuracy_q", got.acc, want.acc);
          if (got.fbeta !== want.fbeta) report_mismatch("fbeta_q", got.fbeta, want.fbeta);
          if (got.flags !== want.flags)
            report_mismatch("undefined_flags", got.flags, want.flags);
        end
      end

      if (s_tvalid && s_tready) begin
        pixels_taken++;
        sc = s_tdata[0 +: SMP_W];
        tr = s_tdata[SMP_W +: SMP_W];
        pred_pos = (sc >= th_score);
        act_pos = (tr > th_truth);
        if (pred_pos && act_pos)       n_tp = sat_incr(n_tp);
        else if (pred_pos)             n_fp = sat_incr(n_fp);
        else if (act_pos)              n_fn = sat_incr(n_fn);
        else                           n_tn = sat_incr(n_tn);

        if (s_tlast) begin
          ltp = n_tp;
          ltn = n_tn;
          lfp = n_fp;
          lfn = n_fn;
          fill = (empty_val > ONE_Q16) ? ONE_Q16 : empty_val;
          want = '0;
          want.tp = n_tp;
          want.tn = n_tn;
          want.fp = n_fp;
          want.fn = n_fn;
          if (ltp != 0) begin
            want.prec = q16_of(ltp, ltp + lfp);
            want.rec  = q16_of(ltp, ltp + lfn);
          end else begin
            want.prec = (lfp != 0) ? '0 : fill;
            want.rec  = (lfn != 0) ? '0 : fill;
          end
          if (ltn + lfp == 0)
            want.flags[0] = 1'b1;
          else
            want.spec = q16_of(ltn, ltn + lfp);
          if (ltp + ltn + lfp + lfn == 0)
            want.flags[1] = 1'b1;
          else
            want.acc = q16_of(ltp + ltn, ltp + ltn + lfp + lfn);
          // F-beta works from the already rounded precision and recall
          if (want.prec != 0 && want.rec != 0) begin
            fnum = (64'd4096 + 64'(beta_sq)) * 64'(want.prec) * 64'(want.rec);
            fden = 64'(beta_sq) * 64'(want.prec) + 64'd4096 * 64'(want.rec);
            fq = (fnum + fden / 2) / fden;
            want.fbeta = (fq > 64'd65536) ? ONE_Q16 : fq[R-1:0];
          end
          expected_scores.push_back(want);
          n_tp = '0;
          n_tn = '0;
          n_fp = '0;
          n_fn = '0;
        end
      end
    end
    pending <= expected_scores.size();
  end

endmodule

>>> dv/tb_binary_classification_scores_top.sv
// ----------------------------------------------------------------------------
// tb_binary_classification_scores_top
// Drives pixel frames into the classification score block under several
// threshold, beta and fallback settings: a directed pass over the corner
// cases, then random frames with sender and receiver idling and a long
// receiver hold-off. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_binary_classification_scores_top;
  import bcs_pkg::*;

  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int SMP_W = SAMPLE_BITS_DEF;
  localparam int PIX_W = ((2*SMP_W+7)/8)*8;
  localparam int RES_W = ((4*CNT_W+5*RATIO_BITS+7)/8)*8;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 4'd12;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASE_PIXELS = 290;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [RATIO_BITS-1:0]    cfg_wdata = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [PIX_W-1:0]         s_tdata = '0;
  logic                     s_tlast = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [RES_W-1:0]         m_tdata;
  logic [FLAG_BITS-1:0]     m_tuser;

  int pending, errors, pixels_taken, frames_checked;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          settings_used = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  logic [15:0] cur_score_th = '0;
  logic [15:0] cur_truth_th = '0;

  always #5 clk = ~clk;

  binary_classification_scores_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  bcs_score_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .pending       (pending),
    .errors        (errors),
    .pixels_taken  (pixels_taken),
    .frames_checked(frames_checked)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [RATIO_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [16:0] score_th, input logic [16:0] truth_th,
                               input logic [16:0] beta, input logic [16:0] empty);
    write_reg(REG_SCORE_TH, score_th);
    write_reg(REG_TRUTH_TH, truth_th);
    write_reg(REG_BETA_SQ, beta);
    write_reg(REG_EMPTY, empty);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_score_th = score_th[15:0];
    cur_truth_th = truth_th[15:0];
    settings_used++;
  endtask

  task automatic send_pixel(input logic [SMP_W-1:0] sc, input logic [SMP_W-1:0] tr,
                            input logic lst);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {tr, sc};
    s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
  endtask

  // wait for every frame result, then give the divider time to settle
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // kinds: 0 uniform, 1 near threshold, 2 above threshold, 3 rails
  function automatic logic [15:0] pick_sample(logic [15:0] th, int unsigned kind);
    logic [15:0] v;
    case (kind)
      0: v = 16'($urandom);
      1: v = 16'(th + $urandom_range(4) - 2);
      2: v = (th == 16'hFFFF) ? th : 16'($urandom_range(65535, th + 1));
      default: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
    return v;
  endfunction

  task automatic run_frames(input int n);
    int sent, len, fkind, k, i;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(250, 30) : $urandom_range(12, 1);
      fkind = $urandom_range(3);
      for (i = 0; i < len; i++) begin
        k = ($urandom_range(3) == 0) ? $urandom_range(3) : fkind;
        send_pixel(pick_sample(cur_score_th, k), pick_sample(cur_truth_th, k),
                   i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle_pct = 18;
    rx_idle_pct = 75;

    // single-pixel frames hit each fallback, then a mixed frame with ties
    apply_setting(17'h08000, 17'h08000, 17'd4096, 17'h10000);
    write_reg(REG_SPARE, 17'h1ABCD);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'hFFFF, 16'h0000, 1'b1);
    send_pixel(16'h0000, 16'hFFFF, 1'b1);
    send_pixel(16'h0000, 16'h0000, 1'b1);
    send_pixel(16'h8000, 16'h8000, 1'b0);
    send_pixel(16'h7FFF, 16'h8001, 1'b0);
    send_pixel(16'h8000, 16'h8001, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
    drain();

    // bit 16 dropped on the thresholds; fallback above one
    apply_setting(17'h10000, 17'h1FFFF, 17'd0, 17'h1FFFF);
    send_pixel(16'h0000, 16'hFFFF, 1'b1);
    send_pixel(16'h5555, 16'hAAAA, 1'b0);
    send_pixel(16'hAAAA, 16'h5555, 1'b1);
    drain();

    apply_setting(17'h0FFFF, 17'h10000, 17'h0FFFF, 17'h00000);
    send_pixel(16'hFFFF, 16'h0001, 1'b1);
    send_pixel(16'hFFFE, 16'h0000, 1'b1);
    send_pixel(16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(16'h0000, 16'h0001, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 1'b0);
    send_pixel(16'h1234, 16'h0000, 1'b1);
    drain();

    apply_setting(17'h01000, 17'h03000, 17'h01800, 17'h0ABCD);
    send_pixel(16'h0000, 16'h0000, 1'b1);
    send_pixel(16'h2000, 16'h4000, 1'b0);
    send_pixel(16'h0800, 16'h4000, 1'b0);
    send_pixel(16'h2000, 16'h1000, 1'b0);
    send_pixel(16'h0FFF, 16'h3000, 1'b1);
    drain();

    apply_setting(17'h08000, 17'h08000, 17'd4096, 17'h10000);
    run_frames(PHASE_PIXELS);
    drain();
    apply_setting(17'h00000, 17'h00000, 17'h0FFFF, 17'h1FFFF);
    run_frames(PHASE_PIXELS);
    drain();

    tx_idle_pct = 75;
    rx_idle_pct = 18;
    apply_setting(17'h0FFFF, 17'h0FFFF, 17'd0, 17'd0);
    run_frames(PHASE_PIXELS);
    drain();
    apply_setting(17'($urandom), 17'($urandom), 17'($urandom),
                  17'($urandom_range(131071)));
    run_frames(PHASE_PIXELS);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_setting(17'h04000, 17'h0C000, 17'h03000, 17'h08000);
    hold_go = 1'b1;
    run_frames(PHASE_PIXELS);
    drain();
    apply_setting(17'($urandom), 17'($urandom), 17'($urandom),
                  17'($urandom_range(131071)));
    run_frames(PHASE_PIXELS);
    drain();

    $display("run covered %0d pixel transfers and %0d scored frames over %0d settings",
             pixels_taken, frames_checked, settings_used);
    $display("mismatches found: %0d", errors);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
design/bcs_pkg.sv
design/bcs_count.sv
design/bcs_div.sv
design/binary_classification_scores_top.sv
dv/bcs_score_checker.sv
dv/tb_binary_classification_scores_top.sv
